[rtl/core/vrc_pkg.sv]
`timescale 1ns / 1ps

package vrc_pkg;

    localparam int SAMPLE_W  = 32;              // signed Q16.16 sample and bounds
    localparam int COLOR_W   = 32;              // packed R,G,B,A register
    localparam int CHAN_N    = 4;               // R, G, B, A
    localparam int CHAN_W    = 8;
    localparam int QUOT_BITS = CHAN_W;          // every used channel quotient fits one byte
    localparam int DIV_W     = 32;              // divisor and scale factor width
    localparam int PROD_W    = DIV_W + CHAN_W;  // factor times channel delta
    localparam int CFG_IDX_W = 3;

    localparam logic [CHAN_W-1:0]   CHAN_FULL      = 8'hFF;
    localparam logic [SAMPLE_W-1:0] MIN_VALUE_RST  = 32'h0000_0000;
    localparam logic [SAMPLE_W-1:0] MAX_VALUE_RST  = 32'h0001_0000;
    localparam logic [COLOR_W-1:0]  LOW_COLOR_RST  = 32'h0000_0000;
    localparam logic [COLOR_W-1:0]  HIGH_COLOR_RST = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_MODE   = 3'd0,
        CFG_MIN_VALUE  = 3'd1,
        CFG_MAX_VALUE  = 3'd2,
        CFG_LOW_COLOR  = 3'd3,
        CFG_HIGH_COLOR = 3'd4
    } vrc_cfg_idx_t;

    typedef enum logic {
        MODE_LINEAR    = 1'b0,
        MODE_DIVERGING = 1'b1
    } vrc_mode_t;

    // How one channel turns its quotient into the final byte.
    typedef struct packed {
        logic [CHAN_W-1:0] base;     // start value of the ramp
        logic              sub;      // round quotient up and subtract it from base
        logic              frc;      // ignore the quotient, emit frc_val
        logic [CHAN_W-1:0] frc_val;
    } vrc_chan_ctl_t;

    // Word carried through the divider stages.
    typedef struct packed {
        logic [DIV_W-1:0]                    dvsr;
        logic [CHAN_N-1:0][PROD_W-1:0]       rem;
        logic [CHAN_N-1:0][QUOT_BITS-1:0]    quot;
        vrc_chan_ctl_t [CHAN_N-1:0]          ctl;
    } vrc_div_word_t;

endpackage

[rtl/core/vrc_divider.sv]
`timescale 1ns / 1ps

module vrc_divider (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vrc_pkg::vrc_div_word_t in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output vrc_pkg::vrc_div_word_t out_word
);
    import vrc_pkg::*;

    // One restoring step per stage, most significant quotient bit first.
    logic [QUOT_BITS-1:0] vld_reg;
    logic [QUOT_BITS-1:0] en;
    logic [QUOT_BITS-1:0] src_vld;
    vrc_div_word_t        src_word  [QUOT_BITS];
    vrc_div_word_t        word_next [QUOT_BITS];
    vrc_div_word_t        word_reg  [QUOT_BITS];

    assign src_vld[0]  = in_valid;
    assign src_word[0] = in_word;
    assign in_ready    = en[0];
    assign en[QUOT_BITS-1] = !vld_reg[QUOT_BITS-1] || out_ready;
    assign out_valid   = vld_reg[QUOT_BITS-1];
    assign out_word    = word_reg[QUOT_BITS-1];

    for (genvar i = 0; i < QUOT_BITS; i++) begin : g_step
        localparam int SH = QUOT_BITS - 1 - i;

        if (i > 0) begin : g_link
            assign src_vld[i]  = vld_reg[i-1];
            assign src_word[i] = word_reg[i-1];
        end
        if (i < QUOT_BITS - 1) begin : g_en
            assign en[i] = !vld_reg[i] || en[i+1];
        end

        always_comb begin
            logic [PROD_W-1:0] dsh;
            dsh = {{(PROD_W-DIV_W){1'b0}}, src_word[i].dvsr} << SH;
            word_next[i] = src_word[i];
            for (int k = 0; k < CHAN_N; k++) begin
                if (src_word[i].rem[k] >= dsh) begin
                    word_next[i].rem[k]      = src_word[i].rem[k] - dsh;
                    word_next[i].quot[k][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en[i]) begin
                vld_reg[i] <= src_vld[i];
            end
            if (en[i]) begin
                word_reg[i] <= word_next[i];
            end
        end
    end

endmodule

[rtl/core/value_to_rgba_colormap_top.sv]
`timescale 1ns / 1ps

// Maps a stream of signed Q16.16 samples to RGBA pixels, one pixel per sample.
// Linear mode ramps each channel from the low color at min_value to the high
// color at max_value, clamped at both ends; diverging mode fades from white
// toward 255 minus the low color for negative samples and toward 255 minus the
// high color otherwise, scaled by max(|min_value|, |max_value|), with alpha at 255.
// The block takes one word per clock while m_tready does not stall it, and it
// holds no state between samples. A pixel passes one prepare stage, one
// multiply stage, eight divider stages (one quotient bit each) and the output
// register. Stalls on m_tready back up through the stages; empty stages still
// fill, so bubbles are squeezed out. Write the registers only while no pixel
// is in flight.

module value_to_rgba_colormap_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    // pixel stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
);
    import vrc_pkg::*;

    typedef struct packed {
        logic [DIV_W-1:0]               fac;   // scale numerator, never above dvsr where the quotient is used
        logic [DIV_W-1:0]               dvsr;
        logic [CHAN_N-1:0][CHAN_W-1:0]  delta; // channel span to scale
        vrc_chan_ctl_t [CHAN_N-1:0]     ctl;
    } prep_t;

    // ------------------------------------------------------------------
    // Configuration registers, always ready; unknown indexes drop.
    // ------------------------------------------------------------------
    vrc_mode_t           mode_reg;
    logic [SAMPLE_W-1:0] min_value_reg;
    logic [SAMPLE_W-1:0] max_value_reg;
    logic [COLOR_W-1:0]  low_color_reg;
    logic [COLOR_W-1:0]  high_color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_LINEAR;
            min_value_reg  <= MIN_VALUE_RST;
            max_value_reg  <= MAX_VALUE_RST;
            low_color_reg  <= LOW_COLOR_RST;
            high_color_reg <= HIGH_COLOR_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (vrc_cfg_idx_t'(cfg_index))
                CFG_MAP_MODE:   mode_reg       <= vrc_mode_t'(cfg_data[0]);
                CFG_MIN_VALUE:  min_value_reg  <= cfg_data;
                CFG_MAX_VALUE:  max_value_reg  <= cfg_data;
                CFG_LOW_COLOR:  low_color_reg  <= cfg_data;
                CFG_HIGH_COLOR: high_color_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stall chain: each stage advances when it is empty or the next one moves.
    // ------------------------------------------------------------------
    logic          s0_vld_reg, s1_vld_reg;
    logic          s0_en, s1_en, out_en;
    logic          div_in_ready, div_out_valid;
    prep_t         s0_reg, s0_next;
    vrc_div_word_t s1_reg, s1_next;
    vrc_div_word_t div_out_word;
    logic [31:0]   m_tdata_next;

    assign out_en   = !m_tvalid || m_tready;
    assign s1_en    = !s1_vld_reg || div_in_ready;
    assign s0_en    = !s0_vld_reg || s1_en;
    assign s_tready = s0_en;

    // ------------------------------------------------------------------
    // Stage 0: reduce the sample to a ratio fac/dvsr and per-channel controls.
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [SAMPLE_W:0] x_ext, mn_ext, mx_ext;
        logic signed [SAMPLE_W:0] lin_num, lin_den, lin_n, lin_d;
        logic signed [SAMPLE_W:0] ax, amn, amx, dv_m;
        logic                     sel_lo, sel_hi, m_zero, neg;
        logic [CHAN_W-1:0]        lo, hi, col;
        logic [COLOR_W-1:0]       dv_color;

        lo  = '0;
        hi  = '0;
        col = '0;

        x_ext  = {s_tdata[SAMPLE_W-1], s_tdata};
        mn_ext = {min_value_reg[SAMPLE_W-1], min_value_reg};
        mx_ext = {max_value_reg[SAMPLE_W-1], max_value_reg};

        // linear: flip a reversed span so the divisor is never negative;
        // a zero span falls out of the end tests below
        lin_num = x_ext - mn_ext;
        lin_den = mx_ext - mn_ext;
        lin_n   = lin_den < 0 ? -lin_num : lin_num;
        lin_d   = lin_den < 0 ? -lin_den : lin_den;
        sel_lo  = lin_n <= 0;
        sel_hi  = !sel_lo && (lin_n >= lin_d);

        // diverging: magnitude over the larger bound, clamped at one
        neg      = x_ext < 0;
        ax       = neg ? -x_ext : x_ext;
        amn      = mn_ext < 0 ? -mn_ext : mn_ext;
        amx      = mx_ext < 0 ? -mx_ext : mx_ext;
        dv_m     = amx > amn ? amx : amn;
        m_zero   = dv_m == 0;
        dv_color = neg ? low_color_reg : high_color_reg;

        s0_next = '0;
        if (mode_reg == MODE_DIVERGING) begin
            s0_next.dvsr = m_zero ? DIV_W'(1) : dv_m[DIV_W-1:0];
            if (m_zero) begin
                s0_next.fac = DIV_W'(ax != 0);
            end else begin
                s0_next.fac = ax > dv_m ? dv_m[DIV_W-1:0] : ax[DIV_W-1:0];
            end
            for (int k = 0; k < CHAN_N; k++) begin
                col = dv_color[COLOR_W-1-CHAN_W*k -: CHAN_W];
                s0_next.delta[k]       = col;
                s0_next.ctl[k].base    = CHAN_FULL;
                s0_next.ctl[k].sub     = 1'b1;
                s0_next.ctl[k].frc     = (k == CHAN_N - 1);
                s0_next.ctl[k].frc_val = CHAN_FULL;
            end
        end else begin
            s0_next.fac  = lin_n[DIV_W-1:0];
            s0_next.dvsr = lin_d[DIV_W-1:0];
            for (int k = 0; k < CHAN_N; k++) begin
                lo = low_color_reg[COLOR_W-1-CHAN_W*k -: CHAN_W];
                hi = high_color_reg[COLOR_W-1-CHAN_W*k -: CHAN_W];
                s0_next.delta[k]       = hi < lo ? lo - hi : hi - lo;
                s0_next.ctl[k].base    = lo;
                s0_next.ctl[k].sub     = hi < lo;
                s0_next.ctl[k].frc     = sel_lo || sel_hi;
                s0_next.ctl[k].frc_val = sel_lo ? lo : hi;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: scale each channel span by the numerator.
    // ------------------------------------------------------------------
    always_comb begin
        s1_next      = '0;
        s1_next.dvsr = s0_reg.dvsr;
        s1_next.ctl  = s0_reg.ctl;
        for (int k = 0; k < CHAN_N; k++) begin
            s1_next.rem[k] = PROD_W'(s0_reg.fac) * PROD_W'(s0_reg.delta[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
        end else begin
            if (s0_en) s0_vld_reg <= s_tvalid;
            if (s1_en) s1_vld_reg <= s0_vld_reg;
        end
        if (s0_en) s0_reg <= s0_next;
        if (s1_en) s1_reg <= s1_next;
    end

    // ------------------------------------------------------------------
    // Stages 2..9: quotient, one bit per stage.
    // ------------------------------------------------------------------
    vrc_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_vld_reg),
        .in_ready  (div_in_ready),
        .in_word   (s1_reg),
        .out_valid (div_out_valid),
        .out_ready (out_en),
        .out_word  (div_out_word)
    );

    // ------------------------------------------------------------------
    // Output stage: round up where the ramp subtracts, apply forced values.
    // ------------------------------------------------------------------
    always_comb begin
        logic [CHAN_W-1:0] q, qc;
        for (int k = 0; k < CHAN_N; k++) begin
            q  = div_out_word.quot[k];
            qc = q + CHAN_W'(div_out_word.rem[k] != '0);
            if (div_out_word.ctl[k].frc) begin
                m_tdata_next[CHAN_W*k +: CHAN_W] = div_out_word.ctl[k].frc_val;
            end else if (div_out_word.ctl[k].sub) begin
                m_tdata_next[CHAN_W*k +: CHAN_W] = div_out_word.ctl[k].base - qc;
            end else begin
                m_tdata_next[CHAN_W*k +: CHAN_W] = div_out_word.ctl[k].base + q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_en) begin
            m_tvalid <= div_out_valid;
        end
        if (out_en) m_tdata <= m_tdata_next;
    end

endmodule
